// ===== rtl/docal_pkg.sv =====
// Shared constants, codes and controller interface types for the DAC offset calibrator.
`default_nettype none
package docal_pkg;

  localparam int DAC_MIDPOINT = 128;
  localparam int PROBE_STEP   = 16;
  localparam int RANGE_LIMIT  = 16384;
  localparam int POLL_LIMIT   = 2000000;

  localparam int PROBE_UP_I = (DAC_MIDPOINT + PROBE_STEP > 255) ?
                              DAC_MIDPOINT - PROBE_STEP : DAC_MIDPOINT + PROBE_STEP;
  localparam int PROBE_DN_I = (DAC_MIDPOINT - PROBE_STEP < 0) ?
                              DAC_MIDPOINT + PROBE_STEP : DAC_MIDPOINT - PROBE_STEP;

  localparam logic [7:0]  DAC_MID  = 8'(DAC_MIDPOINT);
  localparam logic [7:0]  PROBE_UP = 8'(PROBE_UP_I);
  localparam logic [7:0]  PROBE_DN = 8'(PROBE_DN_I);
  localparam logic [16:0] RANGE_LIM = 17'(RANGE_LIMIT);
  localparam logic [20:0] POLL_LIM  = 21'(POLL_LIMIT);

  localparam int SUM_W = 35;
  localparam int CNT_W = 18;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_POLL   = 2'd2;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_INIT  = 2'd1;
  localparam logic [1:0] PH_PROBE = 2'd2;
  localparam logic [1:0] PH_ITER  = 2'd3;

  localparam logic [3:0] REG_TARGET    = 4'd0;
  localparam logic [3:0] REG_TOLERANCE = 4'd1;
  localparam logic [3:0] REG_DIRECTION = 4'd2;
  localparam logic [3:0] REG_MAX_ITER  = 4'd3;
  localparam logic [3:0] REG_WINDOW    = 4'd4;
  localparam logic [3:0] REG_SETTLE    = 4'd5;
  localparam logic [3:0] REG_SETTLE_TOL = 4'd6;
  localparam logic [3:0] REG_MAX_WIN   = 4'd7;

  localparam logic       EV_DAC    = 1'b0;
  localparam logic       EV_FINISH = 1'b1;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic avg_step;
    logic eval_step;
    logic plan_step;
  } dc_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic go_div;
    logic go_eval;
    logic div_done;
    logic avg_eval;
    logic eval_plan;
  } dc_stat_t;

endpackage
`default_nettype wire

// ===== rtl/docal_div.sv =====
// Bit-serial signed divider for the cumulative average, one quotient bit per cycle.
`default_nettype none
module docal_div
  import docal_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [SUM_W-1:0] dividend,
  input  wire logic        [CNT_W-1:0] divisor,
  output logic                         done,
  output logic signed [15:0]           quotient
);

  localparam int STEPS = SUM_W;
  localparam int CW = $clog2(STEPS);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[SUM_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = dividend[SUM_W-1];
      quo_nxt  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = CNT_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CNT_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      if (cnt_r == CW'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? $signed(-quo_r[15:0]) : $signed(quo_r[15:0]);

endmodule
`default_nettype wire

// ===== rtl/docal_ctrl.sv =====
// Sequencing state machine: request intake, divide, settle check, evaluation and search.
`default_nettype none
module docal_ctrl
  import docal_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dc_stat_t st,
  output dc_cmd_t       cmd
);

  localparam logic [2:0] ST_IN     = 3'd0;
  localparam logic [2:0] ST_DSTART = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_AVG    = 3'd3;
  localparam logic [2:0] ST_EVAL   = 3'd4;
  localparam logic [2:0] ST_PLAN   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IN) && !st.out_busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.accept    = accept;
    cmd.div_start = (state_r == ST_DSTART);
    cmd.avg_step  = (state_r == ST_AVG);
    cmd.eval_step = (state_r == ST_EVAL);
    cmd.plan_step = (state_r == ST_PLAN);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IN: begin
        if (accept && st.go_div) state_nxt = ST_DSTART;
        else if (accept && st.go_eval) state_nxt = ST_EVAL;
      end
      ST_DSTART: state_nxt = ST_DIV;
      ST_DIV: begin
        if (st.div_done) state_nxt = ST_AVG;
      end
      ST_AVG:  state_nxt = st.avg_eval ? ST_EVAL : ST_IN;
      ST_EVAL: state_nxt = st.eval_plan ? ST_PLAN : ST_IN;
      ST_PLAN: state_nxt = ST_IN;
      default: state_nxt = ST_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IN;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    st.div_done |-> state_r == ST_DIV) else $error("divider finished outside divide state");
  a_start_then_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DSTART |=> state_r == ST_DIV) else $error("divide did not follow start");
  a_plan_returns: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PLAN |=> state_r == ST_IN) else $error("search step did not return to intake");
`endif

endmodule
`default_nettype wire

// ===== rtl/docal_dp.sv =====
// Datapath of the calibrator: settings, averaging accumulators, search state and result register.
`default_nettype none
module docal_dp
  import docal_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic [1:0]         in_command,
  input  wire logic signed [15:0] in_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_event_kind,
  output logic [7:0]              out_dac_value,
  output logic signed [15:0]      out_measured,
  output logic                    out_ok,
  input  wire dc_cmd_t            cmd,
  output dc_stat_t                st,
  output logic signed [SUM_W-1:0] div_dividend,
  output logic [CNT_W-1:0]        div_divisor,
  input  wire logic               div_done,
  input  wire logic signed [15:0] div_quotient
);

  logic signed [15:0] tgt_r;
  logic [14:0] tol_r, stol_r;
  logic        dir_r;
  logic [7:0]  maxit_r, maxwin_r;
  logic [10:0] wsz_r;
  logic [15:0] settle_r;

  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  cur_r, cur_nxt, lo_r, lo_nxt, hi_r, hi_nxt, iter_r, iter_nxt;
  logic        slope_r, slope_nxt;
  logic [7:0]  bdac_r, bdac_nxt;
  logic signed [15:0] base_r, base_nxt, brd_r, brd_nxt, last_r, last_nxt, prev_r, prev_nxt;
  logic [16:0] berr_r, berr_nxt;
  logic signed [26:0] wsum_r, wsum_nxt;
  logic signed [SUM_W-1:0] tsum_r, tsum_nxt;
  logic [CNT_W-1:0] tcnt_r, tcnt_nxt;
  logic        havep_r, havep_nxt;
  logic [9:0]  fill_r, fill_nxt;
  logic [15:0] disc_r, disc_nxt;
  logic [7:0]  wd_r, wd_nxt;
  logic [20:0] empty_r, empty_nxt;

  logic        ov_r, ov_nxt, okv_r, okv_nxt, kind_r, kind_nxt;
  logic [7:0]  odac_r, odac_nxt;
  logic signed [15:0] omeas_r, omeas_nxt;

  logic [10:0] n_eff, fill1;
  logic [20:0] empty1;
  logic        active;
  logic signed [26:0] wsum_add;
  logic signed [17:0] ediff;
  logic [16:0] err;
  logic signed [16:0] adiff;
  logic [16:0] amag;
  logic        settled;
  logic [7:0]  wd_inc;
  logic        go_up, stop;
  logic [7:0]  nlo, nhi, nmid;
  logic        nb;
  logic        bm_en, fin_en, fin_ok;
  logic [7:0]  bm_dac, fin_dac;
  logic [1:0]  bm_ph;
  logic signed [15:0] fin_rd;
  logic [16:0] fin_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r    <= '0;
      tol_r    <= '0;
      dir_r    <= 1'b1;
      maxit_r  <= 8'd8;
      wsz_r    <= 11'd16;
      settle_r <= '0;
      stol_r   <= '0;
      maxwin_r <= 8'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET:     tgt_r    <= $signed(cfg_wdata);
        REG_TOLERANCE:  tol_r    <= cfg_wdata[14:0];
        REG_DIRECTION:  dir_r    <= cfg_wdata[0];
        REG_MAX_ITER:   maxit_r  <= cfg_wdata[7:0];
        REG_WINDOW:     wsz_r    <= cfg_wdata[10:0];
        REG_SETTLE:     settle_r <= cfg_wdata;
        REG_SETTLE_TOL: stol_r   <= cfg_wdata[14:0];
        REG_MAX_WIN:    maxwin_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (wsz_r == 11'd0) n_eff = 11'd1;
    else if (wsz_r > 11'd1024) n_eff = 11'd1024;
    else n_eff = wsz_r;
  end

  assign active   = (phase_r != PH_IDLE);
  assign fill1    = {1'b0, fill_r} + 11'd1;
  assign empty1   = empty_r + 21'd1;
  assign wsum_add = wsum_r + 27'(in_sample);
  assign ediff    = 18'(tgt_r) - 18'(last_r);
  assign err      = ediff[17] ? 17'(-ediff) : 17'(ediff);
  assign adiff    = 17'(div_quotient) - 17'(prev_r);
  assign amag     = adiff[16] ? 17'(-adiff) : 17'(adiff);
  assign settled  = havep_r && (amag <= {2'b00, stol_r});
  assign wd_inc   = wd_r + 8'd1;
  assign nb       = (err < berr_r);

  always_comb begin
    st.out_busy  = ov_r && !out_ready;
    st.go_div    = (in_command == CMD_SAMPLE) && active && (disc_r == 16'd0)
                   && (fill1 >= n_eff);
    st.go_eval   = (in_command == CMD_POLL) && active && (empty1 >= POLL_LIM);
    st.div_done  = div_done;
    st.avg_eval  = settled || (wd_inc >= maxwin_r);
    st.eval_plan = (phase_r != PH_INIT) && (err > {2'b00, tol_r});
  end

  assign div_dividend = tsum_r;
  assign div_divisor  = tcnt_r;

  always_comb begin
    phase_nxt = phase_r; cur_nxt = cur_r; lo_nxt = lo_r; hi_nxt = hi_r;
    iter_nxt = iter_r; slope_nxt = slope_r; bdac_nxt = bdac_r; base_nxt = base_r;
    brd_nxt = brd_r; berr_nxt = berr_r; last_nxt = last_r; prev_nxt = prev_r;
    wsum_nxt = wsum_r; tsum_nxt = tsum_r; tcnt_nxt = tcnt_r; havep_nxt = havep_r;
    fill_nxt = fill_r; disc_nxt = disc_r; wd_nxt = wd_r; empty_nxt = empty_r;
    ov_nxt = ov_r && !out_ready; kind_nxt = kind_r; odac_nxt = odac_r;
    omeas_nxt = omeas_r; okv_nxt = okv_r;
    bm_en = 1'b0; bm_dac = cur_r; bm_ph = phase_r;
    fin_en = 1'b0; fin_ok = 1'b0; fin_dac = bdac_r; fin_rd = brd_r;
    go_up = 1'b0; stop = 1'b0; nlo = lo_r; nhi = hi_r; nmid = cur_r;
    fin_mag = '0;

    if (cmd.accept) begin
      case (in_command)
        CMD_START: begin
          if (!active) begin
            bm_en = 1'b1; bm_dac = DAC_MID; bm_ph = PH_INIT;
          end
        end
        CMD_SAMPLE: begin
          if (active) begin
            empty_nxt = '0;
            if (disc_r != 16'd0) begin
              disc_nxt = disc_r - 16'd1;
            end else if (fill1 < n_eff) begin
              wsum_nxt = wsum_add;
              fill_nxt = fill1[9:0];
            end else begin
              tsum_nxt = tsum_r + SUM_W'(wsum_add);
              tcnt_nxt = tcnt_r + CNT_W'(n_eff);
              wsum_nxt = '0;
              fill_nxt = '0;
            end
          end
        end
        CMD_POLL: begin
          if (active) begin
            empty_nxt = empty1;
            if (empty1 >= POLL_LIM) last_nxt = 16'sh7FFF;
          end
        end
        default: ;
      endcase
    end

    if (cmd.avg_step) begin
      last_nxt = div_quotient;
      if (!settled) begin
        prev_nxt  = div_quotient;
        havep_nxt = 1'b1;
        wd_nxt    = wd_inc;
      end
    end

    if (cmd.eval_step) begin
      if (phase_r == PH_INIT) begin
        base_nxt = last_r; bdac_nxt = cur_r; brd_nxt = last_r; berr_nxt = err;
        if (err <= {2'b00, tol_r}) begin
          fin_en = 1'b1; fin_ok = 1'b1; fin_dac = cur_r; fin_rd = last_r;
        end else begin
          bm_en = 1'b1; bm_ph = PH_PROBE;
          bm_dac = dir_r ? PROBE_UP : PROBE_DN;
        end
      end else begin
        if (nb) begin
          berr_nxt = err; bdac_nxt = cur_r; brd_nxt = last_r;
          fin_dac = cur_r; fin_rd = last_r;
        end
        if (err <= {2'b00, tol_r}) begin
          fin_en = 1'b1; fin_ok = 1'b1;
        end else if (phase_r == PH_PROBE) begin
          if (last_r == base_r) slope_nxt = dir_r;
          else slope_nxt = ((last_r > base_r) == (cur_r > DAC_MID));
          lo_nxt = '0; hi_nxt = 8'hFF; iter_nxt = '0;
        end
      end
    end

    if (cmd.plan_step) begin
      go_up = slope_r ? (last_r < tgt_r) : (last_r > tgt_r);
      if (iter_r >= maxit_r) begin
        stop = 1'b1;
      end else if (go_up) begin
        if (cur_r == 8'hFF) stop = 1'b1;
        else nlo = cur_r + 8'd1;
      end else begin
        if (cur_r == 8'h00) stop = 1'b1;
        else nhi = cur_r - 8'd1;
      end
      if (!stop) begin
        lo_nxt = nlo; hi_nxt = nhi;
        if (nlo > nhi) begin
          stop = 1'b1;
        end else begin
          nmid = nlo + ((nhi - nlo) >> 1);
          if (nmid == cur_r) stop = 1'b1;
        end
      end
      if (stop) begin
        fin_en = 1'b1; fin_ok = 1'b0;
      end else begin
        iter_nxt = iter_r + 8'd1;
        bm_en = 1'b1; bm_dac = nmid; bm_ph = PH_ITER;
      end
    end

    if (bm_en) begin
      cur_nxt = bm_dac; wsum_nxt = '0; tsum_nxt = '0; tcnt_nxt = '0; fill_nxt = '0;
      disc_nxt = settle_r; wd_nxt = '0; havep_nxt = 1'b0; prev_nxt = '0;
      empty_nxt = '0; phase_nxt = bm_ph;
      ov_nxt = 1'b1; kind_nxt = EV_DAC; odac_nxt = bm_dac; omeas_nxt = '0; okv_nxt = 1'b0;
    end

    if (fin_en) begin
      fin_mag = fin_rd[15] ? 17'(-17'(fin_rd)) : 17'(fin_rd);
      phase_nxt = PH_IDLE;
      ov_nxt = 1'b1; kind_nxt = EV_FINISH;
      if (fin_mag > RANGE_LIM) begin
        odac_nxt = DAC_MID; omeas_nxt = (phase_r == PH_INIT) ? last_r : base_r;
        okv_nxt = 1'b0;
      end else begin
        odac_nxt = fin_dac; omeas_nxt = fin_rd; okv_nxt = fin_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; cur_r <= '0; lo_r <= '0; hi_r <= 8'hFF; iter_r <= '0;
      slope_r <= 1'b0; bdac_r <= '0; base_r <= '0; brd_r <= '0; berr_r <= '0;
      last_r <= '0; prev_r <= '0; wsum_r <= '0; tsum_r <= '0; tcnt_r <= '0;
      havep_r <= 1'b0; fill_r <= '0; disc_r <= '0; wd_r <= '0; empty_r <= '0;
      ov_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; cur_r <= cur_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
      iter_r <= iter_nxt; slope_r <= slope_nxt; bdac_r <= bdac_nxt; base_r <= base_nxt;
      brd_r <= brd_nxt; berr_r <= berr_nxt; last_r <= last_nxt; prev_r <= prev_nxt;
      wsum_r <= wsum_nxt; tsum_r <= tsum_nxt; tcnt_r <= tcnt_nxt; havep_r <= havep_nxt;
      fill_r <= fill_nxt; disc_r <= disc_nxt; wd_r <= wd_nxt; empty_r <= empty_nxt;
      ov_r <= ov_nxt;
    end
    kind_r <= kind_nxt; odac_r <= odac_nxt; omeas_r <= omeas_nxt; okv_r <= okv_nxt;
  end

  assign out_valid      = ov_r;
  assign out_event_kind = kind_r;
  assign out_dac_value  = odac_r;
  assign out_measured   = omeas_r;
  assign out_ok         = okv_r;

endmodule
`default_nettype wire

// ===== rtl/dac_offset_search_calibrator.sv =====
// Top level of the DAC offset search calibrator: controller, datapath and serial divider.
// Usage:
// The request channel (in_valid/in_ready) carries a command and an ADC sample. A start
// request moves the trim DAC to its midpoint; sample requests feed the averaging; poll
// requests count empty polls towards a timeout. The result channel (out_valid/out_ready)
// reports either a new DAC code to apply or the finished stage with its reading and ok flag.
// A start request shows its result in the next cycle. A request that closes an averaging
// window runs the bit-serial divider and then the settle check and, when due, the evaluation
// and search steps before the next request is taken. A finished result waits in the output
// register; the block takes a new request in the same cycle as that result is taken or when
// the register is empty, so a stalled receiver holds off further requests. Settings are
// written through cfg_we, cfg_index and cfg_wdata; the user must do so only while the block
// is idle; the block does not enforce this. Reset restores idle and the default settings.
`default_nettype none
module dac_offset_search_calibrator
  import docal_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_command,
  input  wire logic signed [15:0] in_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_event_kind,
  output logic [7:0]              out_dac_value,
  output logic signed [15:0]      out_measured,
  output logic                    out_ok
);

  dc_cmd_t  cmd;
  dc_stat_t st;
  logic signed [SUM_W-1:0] dividend;
  logic [CNT_W-1:0]        divisor;
  logic                    div_done;
  logic signed [15:0]      quotient;

  docal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  docal_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_command     (in_command),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_dac_value  (out_dac_value),
    .out_measured   (out_measured),
    .out_ok         (out_ok),
    .cmd            (cmd),
    .st             (st),
    .div_dividend   (dividend),
    .div_divisor    (divisor),
    .div_done       (div_done),
    .div_quotient   (quotient)
  );

  docal_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule
`default_nettype wire
